>>> rtl/ffba_pkg.sv
package ffba_pkg;

    localparam int unsigned FREE_SLOTS_DEF = 16;
    localparam int unsigned USED_SLOTS_DEF = 16;

    localparam logic [1:0] FUNC_CLAIM   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REALLOC = 2'd2;
    localparam logic [1:0] FUNC_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOADDR  = 2'd2;
    localparam logic [1:0] ST_NODESC  = 2'd3;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    localparam logic [31:0] HEAP_LEN_RST = 32'd65536;

    // Per-cycle command to every cell of a chain.
    typedef struct packed {
        logic        restart;
        logic        ins_front;   // shift right, insert at head
        logic        del;         // shift left from pos
        logic        upd;         // rewrite one entry in place
        logic [8:0]  pos;
        logic [31:0] start;
        logic [31:0] size;
    } t_chain_cmd;

endpackage

>>> rtl/ffba_cell.sv
// One table entry: holds start/size/valid, takes its left or right neighbor.
module ffba_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                i_clk,
    input  ffba_pkg::t_chain_cmd i_cmd,
    input  logic                i_rst_val,
    input  logic [31:0]         i_rst_start,
    input  logic [31:0]         i_rst_size,
    input  logic                i_left_v,
    input  logic [31:0]         i_left_start,
    input  logic [31:0]         i_left_size,
    input  logic                i_right_v,
    input  logic [31:0]         i_right_start,
    input  logic [31:0]         i_right_size,
    output logic                o_v,
    output logic [31:0]         o_start,
    output logic [31:0]         o_size
);
    import ffba_pkg::*;

    logic        r_v;
    logic [31:0] r_start, r_size;
    logic        n_v;
    logic [31:0] n_start, n_size;
    logic [8:0]  w_me;

    assign w_me = 9'(IDX);

    always_comb begin
        n_v = r_v; n_start = r_start; n_size = r_size;
        if (i_cmd.restart) begin
            n_v = i_rst_val; n_start = i_rst_start; n_size = i_rst_size;
        end else if (i_cmd.ins_front) begin
            if (w_me == 9'd0) begin
                n_v = 1'b1; n_start = i_cmd.start; n_size = i_cmd.size;
            end else begin
                n_v = i_left_v; n_start = i_left_start; n_size = i_left_size;
            end
        end else if (i_cmd.del) begin
            if (w_me >= i_cmd.pos) begin
                n_v = i_right_v; n_start = i_right_start; n_size = i_right_size;
            end
        end else if (i_cmd.upd && w_me == i_cmd.pos) begin
            n_start = i_cmd.start; n_size = i_cmd.size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v; r_start <= n_start; r_size <= n_size;
    end

    assign o_v = r_v;
    assign o_start = r_start;
    assign o_size = r_size;
endmodule

>>> rtl/ffba_chain.sv
// Row of cells; reports per-entry contents.
module ffba_chain #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                 i_clk,
    input  ffba_pkg::t_chain_cmd i_cmd,
    input  logic [31:0]          i_rst_start,
    input  logic [31:0]          i_rst_size,
    input  logic                 i_rst_one,
    output logic [SLOTS-1:0]     o_v,
    output logic [SLOTS-1:0][31:0] o_start,
    output logic [SLOTS-1:0][31:0] o_size
);
    import ffba_pkg::*;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        logic        w_lv, w_rv;
        logic [31:0] w_ls, w_lz, w_rs, w_rz;
        if (g == 0) begin : g_l0
            assign w_lv = 1'b0; assign w_ls = '0; assign w_lz = '0;
        end else begin : g_ln
            assign w_lv = o_v[g-1]; assign w_ls = o_start[g-1]; assign w_lz = o_size[g-1];
        end
        if (g == SLOTS-1) begin : g_re
            assign w_rv = 1'b0; assign w_rs = '0; assign w_rz = '0;
        end else begin : g_rn
            assign w_rv = o_v[g+1]; assign w_rs = o_start[g+1]; assign w_rz = o_size[g+1];
        end
        ffba_cell #(.IDX(g)) u_cell (
            .i_clk(i_clk), .i_cmd(i_cmd),
            .i_rst_val((g == 0) ? i_rst_one : 1'b0),
            .i_rst_start((g == 0) ? i_rst_start : 32'd0),
            .i_rst_size((g == 0) ? i_rst_size : 32'd0),
            .i_left_v(w_lv), .i_left_start(w_ls), .i_left_size(w_lz),
            .i_right_v(w_rv), .i_right_start(w_rs), .i_right_size(w_rz),
            .o_v(o_v[g]), .o_start(o_start[g]), .o_size(o_size[g])
        );
    end
endmodule

>>> rtl/first_fit_block_allocator.sv
// Channel  | Direction | Handshake            | Payload
// -------- | --------- | -------------------- | -----------------------------------
// command  | in        | i_start & !o_busy    | i_func, i_req_size, i_block_addr
// result   | out       | o_done (one cycle)   | o_status, o_granted_addr,
//          |           |                      | o_previous_size, o_free_total
// config   | in        | i_cfg_valid&o_cfg_ready | i_cfg_index, i_cfg_wdata
//
// Each transaction passes a search state (parallel compare of every free
// cell and every used cell, priority pick), then an apply state that decides
// the status and at its end shifts or rewrites one entry of the chains, and
// then o_done pulses for one cycle, in which the block is idle again and can
// take the next command. Reset (sync, active low) and any config write
// restart the heap: one free block (heap_base, heap_length), no used blocks;
// busy stays high while that restart is applied. Results cannot be stalled.
module first_fit_block_allocator #(
    parameter int unsigned FREE_SLOTS = ffba_pkg::FREE_SLOTS_DEF,
    parameter int unsigned USED_SLOTS = ffba_pkg::USED_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_block_addr,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_addr,
    output logic [31:0] o_previous_size,
    output logic [31:0] o_free_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);
    import ffba_pkg::*;

    localparam int unsigned FW = $clog2(FREE_SLOTS);
    localparam int unsigned UW = $clog2(USED_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_APPLY  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_func;
    logic [31:0] r_size, r_addr;
    logic [31:0] r_base, r_len, r_sum;
    logic        r_restart;

    // search results
    logic        r_fhit, r_uhit, r_ffull, r_ufull, r_exact;
    logic [FW-1:0] r_fidx;
    logic [UW-1:0] r_uidx;
    logic [31:0] r_fstart, r_fsize, r_ustart, r_usize;

    t_chain_cmd w_fcmd, w_ucmd;
    logic [FREE_SLOTS-1:0] w_fv;
    logic [FREE_SLOTS-1:0][31:0] w_fs, w_fz;
    logic [USED_SLOTS-1:0] w_uv;
    logic [USED_SLOTS-1:0][31:0] w_us, w_uz;

    ffba_chain #(.SLOTS(FREE_SLOTS)) u_free (
        .i_clk(i_clk), .i_cmd(w_fcmd), .i_rst_start(r_base), .i_rst_size(r_len),
        .i_rst_one(1'b1), .o_v(w_fv), .o_start(w_fs), .o_size(w_fz));
    ffba_chain #(.SLOTS(USED_SLOTS)) u_used (
        .i_clk(i_clk), .i_cmd(w_ucmd), .i_rst_start(32'd0), .i_rst_size(32'd0),
        .i_rst_one(1'b0), .o_v(w_uv), .o_start(w_us), .o_size(w_uz));

    assign o_busy = (r_state != S_IDLE) || r_restart;
    assign o_cfg_ready = (r_state == S_IDLE);

    // Search state: priority pick over cells (valid entries form a prefix).
    logic          w_fhit, w_uhit;
    logic [FW-1:0] w_fidx;
    logic [UW-1:0] w_uidx;
    always_comb begin
        w_fhit = 1'b0; w_fidx = '0;
        for (int i = FREE_SLOTS-1; i >= 0; i--) begin
            if (w_fv[i] && w_fz[i] >= r_size) begin
                w_fhit = 1'b1; w_fidx = FW'(i);
            end
        end
        w_uhit = 1'b0; w_uidx = '0;
        for (int i = USED_SLOTS-1; i >= 0; i--) begin
            if (w_uv[i] && w_us[i] == r_addr) begin
                w_uhit = 1'b1; w_uidx = UW'(i);
            end
        end
    end

    // Apply state: decide and drive chain commands.
    logic       w_claim_op, w_free_op, w_do_claim, w_do_free;
    logic [1:0] w_st;
    always_comb begin
        w_claim_op = (r_func == FUNC_CLAIM) ||
                     (r_func == FUNC_REALLOC && r_uhit);
        w_free_op  = (r_func == FUNC_FREE);
        w_st = ST_OK;
        if (r_func == FUNC_REALLOC && !r_uhit) w_st = ST_NOADDR;
        else if (w_claim_op) begin
            if (!r_fhit) w_st = ST_NOFIT;
            else if (r_ufull) w_st = ST_NODESC;
        end else if (w_free_op) begin
            if (!r_uhit) w_st = ST_NOADDR;
            else if (r_ffull) w_st = ST_NODESC;
        end
        w_do_claim = (r_state == S_APPLY) && w_claim_op && (w_st == ST_OK);
        w_do_free  = (r_state == S_APPLY) && w_free_op && (w_st == ST_OK);

        w_fcmd = '0; w_ucmd = '0;
        w_fcmd.restart = r_restart; w_ucmd.restart = r_restart;
        if (w_do_claim) begin
            w_ucmd.ins_front = 1'b1;
            w_ucmd.start = r_fstart; w_ucmd.size = r_size;
            w_fcmd.pos = 9'(r_fidx);
            if (r_exact) w_fcmd.del = 1'b1;
            else begin
                w_fcmd.upd = 1'b1;
                w_fcmd.start = r_fstart + r_size;
                w_fcmd.size = r_fsize - r_size;
            end
        end
        if (w_do_free) begin
            w_fcmd.ins_front = 1'b1;
            w_fcmd.start = r_ustart; w_fcmd.size = r_usize;
            w_ucmd.del = 1'b1; w_ucmd.pos = 9'(r_uidx);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start && !o_busy) n_state = S_SEARCH;
            S_SEARCH: n_state = S_APPLY;
            S_APPLY:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_len     <= HEAP_LEN_RST;
            r_restart <= 1'b1;
            r_sum     <= HEAP_LEN_RST;
            o_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= 1'b0;
            o_done    <= (r_state == S_APPLY);
            if (i_cfg_valid && o_cfg_ready) begin
                r_restart <= 1'b1;
                if (i_cfg_index == REG_BASE) r_base <= i_cfg_wdata;
                else begin
                    r_len <= i_cfg_wdata;
                    r_sum <= i_cfg_wdata;
                end
            end
            if (r_restart && !(i_cfg_valid && o_cfg_ready)) r_sum <= r_len;
            if (w_do_claim) r_sum <= r_sum - r_size;
            if (w_do_free)  r_sum <= r_sum + r_usize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_func <= i_func; r_size <= i_req_size; r_addr <= i_block_addr;
        end
        if (r_state == S_SEARCH) begin
            r_fhit   <= w_fhit;  r_fidx <= w_fidx;
            r_uhit   <= w_uhit;  r_uidx <= w_uidx;
            r_fstart <= w_fs[w_fidx]; r_fsize <= w_fz[w_fidx];
            r_exact  <= (w_fz[w_fidx] == r_size);
            r_ustart <= w_us[w_uidx]; r_usize <= w_uz[w_uidx];
            r_ffull  <= w_fv[FREE_SLOTS-1];
            r_ufull  <= w_uv[USED_SLOTS-1];
        end
        if (r_state == S_APPLY) begin
            o_status        <= w_st;
            o_granted_addr  <= (w_st == ST_OK && w_claim_op) ? r_fstart : 32'd0;
            o_previous_size <= (w_st == ST_OK && r_func == FUNC_REALLOC) ? r_usize : 32'd0;
        end
    end

    assign o_free_total = r_sum;
endmodule

>>> rtl/ffba_checker.sv
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [31:0] o_granted_addr,
    input logic [31:0] o_previous_size
);
    import ffba_pkg::*;

    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done) else $error("done latency");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done twice");
    a_gr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_granted_addr == 32'd0)
        else $error("grant on fail");
    a_prev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_previous_size == 32'd0)
        else $error("prev on fail");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_granted_addr(o_granted_addr),
    .o_previous_size(o_previous_size));
